// ===== hdl/taa_pkg.sv =====
// Shared constants, types and state codes for the triangle area accumulator
package taa_pkg;

    localparam int CoordW    = 32;
    localparam int FracW     = 16;
    localparam int NumCoords = 9;
    localparam int CountW    = 4;
    localparam int FaceVerts = 3;
    localparam int InRawW    = NumCoords * CoordW + CountW;
    localparam int InDataW   = ((InRawW + 7) / 8) * 8;
    localparam int DiffW     = CoordW + 1;
    localparam int MulW      = DiffW + 1;
    localparam int ProdW     = 2 * MulW;
    localparam int HalfW     = DiffW;
    localparam int MagW      = 2 * HalfW;
    localparam int SumW      = 2 * MagW + 2;
    localparam int RootW     = SumW / 2;
    localparam int AreaShift = FracW + 1;
    localparam int AreaW     = RootW - AreaShift;
    localparam int AccW      = 64;
    localparam int IterW     = $clog2(RootW + 1);
    localparam int StepW     = 3;

    // Multiplier sequence, one step per cycle for each cross-product component
    localparam logic [StepW-1:0] StepMulA  = 3'd0;
    localparam logic [StepW-1:0] StepMulB  = 3'd1;
    localparam logic [StepW-1:0] StepDiff  = 3'd2;
    localparam logic [StepW-1:0] StepAbs   = 3'd3;
    localparam logic [StepW-1:0] StepSqLo  = 3'd4;
    localparam logic [StepW-1:0] StepSqMid = 3'd5;
    localparam logic [StepW-1:0] StepSqHi  = 3'd6;
    localparam logic [StepW-1:0] StepLast  = 3'd7;
    localparam logic [1:0]       LastComp  = 2'd2;

    typedef struct packed {
        logic [2:0][DiffW-1:0] d;   // B - A per axis
        logic [2:0][DiffW-1:0] e;   // C - A per axis
        logic                  bad;
        logic                  last;
    } t_face;

    typedef struct packed {
        logic [AccW-1:0] area;
        logic            bad;
    } t_result;

    typedef struct packed {
        logic idle;
        logic emit;
    } t_back_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROOT,
        ST_ACCUM,
        ST_EMIT
    } t_state;

endpackage

// ===== hdl/taa_front.sv =====
// Front stage: unpack a face, form edge vectors and classify the vertex count
module taa_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [taa_pkg::InDataW-1:0]    s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           o_face_valid,
    output taa_pkg::t_face                 o_face,
    input  logic                           i_face_ready
);

    logic           r_valid;
    taa_pkg::t_face r_face;
    taa_pkg::t_face n_face;
    logic           accept;

    assign s_axis_tready = !r_valid || i_face_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Form B-A and C-A with one guard bit
    always_comb begin
        logic [taa_pkg::CoordW-1:0] va;
        logic [taa_pkg::CoordW-1:0] vb;
        logic [taa_pkg::CoordW-1:0] vc;
        for (int i = 0; i < 3; i++) begin
            va = s_axis_tdata[i*taa_pkg::CoordW +: taa_pkg::CoordW];
            vb = s_axis_tdata[(i+3)*taa_pkg::CoordW +: taa_pkg::CoordW];
            vc = s_axis_tdata[(i+6)*taa_pkg::CoordW +: taa_pkg::CoordW];
            n_face.d[i] = {vb[taa_pkg::CoordW-1], vb} - {va[taa_pkg::CoordW-1], va};
            n_face.e[i] = {vc[taa_pkg::CoordW-1], vc} - {va[taa_pkg::CoordW-1], va};
        end
        n_face.bad  = s_axis_tdata[taa_pkg::NumCoords*taa_pkg::CoordW +: taa_pkg::CountW]
                      != taa_pkg::CountW'(taa_pkg::FaceVerts);
        n_face.last = s_axis_tlast;
    end

    // Hold the staged face until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_face_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_face <= n_face;
        end
    end

    assign o_face_valid = r_valid;
    assign o_face       = r_face;

endmodule

// ===== hdl/taa_queue.sv =====
// Two-entry queue between the front stage and the arithmetic back end
module taa_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  taa_pkg::t_face i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output taa_pkg::t_face o_data
);

    taa_pkg::t_face r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           wr;
    logic           rd;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;
    assign o_data  = r_mem[r_rp];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== hdl/taa_back.sv =====
// Back end: cross product on a shared multiplier, bit-serial root, accumulate
module taa_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_face_valid,
    input  taa_pkg::t_face       i_face,
    output logic                 o_pop,
    output logic                 o_res_valid,
    output taa_pkg::t_result     o_res,
    input  logic                 i_res_ready,
    output taa_pkg::t_back_stat  o_stat
);

    taa_pkg::t_state r_state;
    taa_pkg::t_state n_state;

    logic [2:0][taa_pkg::DiffW-1:0] r_d;
    logic [2:0][taa_pkg::DiffW-1:0] r_e;
    logic                           r_bad;
    logic                           r_last;
    logic [taa_pkg::StepW-1:0]      r_step;
    logic [1:0]                     r_comp;
    logic [taa_pkg::ProdW-1:0]      r_prod;
    logic [taa_pkg::ProdW-1:0]      r_p1;
    logic [taa_pkg::ProdW-1:0]      r_cr;
    logic [taa_pkg::MagW-1:0]       r_mag;
    logic [taa_pkg::SumW-1:0]       r_sum;
    logic [taa_pkg::RootW-1:0]      r_root;
    logic [taa_pkg::RootW+1:0]      r_rem;
    logic [taa_pkg::IterW-1:0]      r_iter;
    logic [taa_pkg::AccW-1:0]       r_acc;
    logic                           r_err;

    logic [1:0]                     idx_j;
    logic [1:0]                     idx_k;
    logic signed [taa_pkg::MulW-1:0]  op_a;
    logic signed [taa_pkg::MulW-1:0]  op_b;
    logic signed [taa_pkg::ProdW-1:0] mul_p;
    logic [taa_pkg::HalfW-1:0]      mag_lo;
    logic [taa_pkg::HalfW-1:0]      mag_hi;
    logic [taa_pkg::ProdW-1:0]      cr_abs;
    logic [taa_pkg::RootW+1:0]      rem_sh;
    logic [taa_pkg::RootW+1:0]      trial;
    logic [taa_pkg::AccW:0]         acc_sum;
    logic [taa_pkg::AccW-1:0]       acc_sat;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            taa_pkg::ST_IDLE: begin
                if (i_face_valid) begin
                    n_state = i_face.bad ? taa_pkg::ST_ACCUM : taa_pkg::ST_MUL;
                end
            end
            taa_pkg::ST_MUL: begin
                if (r_step == taa_pkg::StepLast && r_comp == taa_pkg::LastComp) begin
                    n_state = taa_pkg::ST_ROOT;
                end
            end
            taa_pkg::ST_ROOT: begin
                if (r_iter == taa_pkg::IterW'(taa_pkg::RootW - 1)) begin
                    n_state = taa_pkg::ST_ACCUM;
                end
            end
            taa_pkg::ST_ACCUM: begin
                n_state = r_last ? taa_pkg::ST_EMIT : taa_pkg::ST_IDLE;
            end
            taa_pkg::ST_EMIT: begin
                if (i_res_ready) begin
                    n_state = taa_pkg::ST_IDLE;
                end
            end
            default: n_state = taa_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_pop       = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            taa_pkg::ST_IDLE:  o_pop       = i_face_valid;
            taa_pkg::ST_EMIT:  o_res_valid = 1'b1;
            default: begin
                o_pop       = 1'b0;
                o_res_valid = 1'b0;
            end
        endcase
    end

    assign o_res.area  = r_acc;
    assign o_res.bad   = r_err;
    assign o_stat.idle = r_state == taa_pkg::ST_IDLE;
    assign o_stat.emit = o_res_valid && i_res_ready;

    // Component c_i = d_j*e_k - d_k*e_j
    always_comb begin
        case (r_comp)
            2'd0:    begin idx_j = 2'd1; idx_k = 2'd2; end
            2'd1:    begin idx_j = 2'd2; idx_k = 2'd0; end
            default: begin idx_j = 2'd0; idx_k = 2'd1; end
        endcase
    end

    assign mag_lo = r_mag[taa_pkg::HalfW-1:0];
    assign mag_hi = r_mag[taa_pkg::MagW-1:taa_pkg::HalfW];

    // Select multiplier operands for this step
    always_comb begin
        case (r_step)
            taa_pkg::StepMulA: begin
                op_a = {r_d[idx_j][taa_pkg::DiffW-1], r_d[idx_j]};
                op_b = {r_e[idx_k][taa_pkg::DiffW-1], r_e[idx_k]};
            end
            taa_pkg::StepMulB: begin
                op_a = {r_d[idx_k][taa_pkg::DiffW-1], r_d[idx_k]};
                op_b = {r_e[idx_j][taa_pkg::DiffW-1], r_e[idx_j]};
            end
            taa_pkg::StepSqLo: begin
                op_a = {1'b0, mag_lo};
                op_b = {1'b0, mag_lo};
            end
            taa_pkg::StepSqMid: begin
                op_a = {1'b0, mag_hi};
                op_b = {1'b0, mag_lo};
            end
            taa_pkg::StepSqHi: begin
                op_a = {1'b0, mag_hi};
                op_b = {1'b0, mag_hi};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_p  = op_a * op_b;
    assign cr_abs = r_cr[taa_pkg::ProdW-1] ? (~r_cr + 1'b1) : r_cr;

    // One root bit per cycle
    assign rem_sh = {r_rem[taa_pkg::RootW-1:0], r_sum[taa_pkg::SumW-1 -: 2]};
    assign trial  = {r_root, 2'b01};

    // Saturating add of the truncated area
    assign acc_sum = {1'b0, r_acc}
                   + (taa_pkg::AccW+1)'(r_root[taa_pkg::RootW-1:taa_pkg::AreaShift]);
    assign acc_sat = acc_sum[taa_pkg::AccW] ? '1 : acc_sum[taa_pkg::AccW-1:0];

    // Control state, accumulator and error flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= taa_pkg::ST_IDLE;
            r_acc   <= '0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == taa_pkg::ST_ACCUM) begin
                if (r_bad) begin
                    r_err <= 1'b1;
                end else begin
                    r_acc <= acc_sat;
                end
            end else if (r_state == taa_pkg::ST_EMIT && i_res_ready) begin
                r_acc <= '0;
                r_err <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            taa_pkg::ST_IDLE: begin
                if (i_face_valid) begin
                    r_d    <= i_face.d;
                    r_e    <= i_face.e;
                    r_bad  <= i_face.bad;
                    r_last <= i_face.last;
                    r_step <= '0;
                    r_comp <= '0;
                    r_sum  <= '0;
                end
            end
            taa_pkg::ST_MUL: begin
                r_prod <= mul_p;
                r_step <= r_step + 1'b1;
                case (r_step)
                    taa_pkg::StepMulB:  r_p1  <= r_prod;
                    taa_pkg::StepDiff:  r_cr  <= r_p1 - r_prod;
                    taa_pkg::StepAbs:   r_mag <= cr_abs[taa_pkg::MagW-1:0];
                    taa_pkg::StepSqMid: r_sum <= r_sum + taa_pkg::SumW'(r_prod);
                    taa_pkg::StepSqHi:
                        r_sum <= r_sum + (taa_pkg::SumW'(r_prod) << (taa_pkg::HalfW + 1));
                    taa_pkg::StepLast: begin
                        r_sum <= r_sum + (taa_pkg::SumW'(r_prod) << (2 * taa_pkg::HalfW));
                        r_comp <= r_comp + 1'b1;
                        r_rem  <= '0;
                        r_root <= '0;
                        r_iter <= '0;
                    end
                    default: ;
                endcase
            end
            taa_pkg::ST_ROOT: begin
                r_sum  <= r_sum << 2;
                r_iter <= r_iter + 1'b1;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[taa_pkg::RootW-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[taa_pkg::RootW-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/triangle_area_accumulator_core.sv =====
// Top level of the triangle area accumulator: front, queue, back end, output register
//
// Usage:
//   Slave channel s_axis carries one triangle per transaction: nine Q16.16
//   coordinates and a vertex count in tdata, the end-of-object mark in tlast.
//   Master channel m_axis gives one transaction per object: the Q48.16 area
//   sum in tdata and the bad-face flag in tuser, sent on the face marked last.
//   In the back end a good triangle goes through a load, cross product and
//   squaring on one shared 34x34 multiplier, a bit-serial square root and
//   an accumulate; a bad face goes from the load straight to the accumulate.
//   The face marked last adds a hand-over to the output register. The back
//   end takes no new face until it is through with the one it holds.
//   A front register and a two-entry queue let up to three faces wait while
//   the back end works. When the receiver stalls, the result stays in the
//   output register; the back end holds its next result until the register
//   frees, and the queue then fills and drops s_axis_tready.
//   Reset (synchronous, active low) empties all stages and clears the sum
//   and the error flag.
module triangle_area_accumulator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz (32 each), vertex_count (4), pad
    input  logic [taa_pkg::InDataW-1:0]   s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // area_sum (64)
    output logic [taa_pkg::AccW-1:0]      m_axis_tdata,
    // bad_face (1)
    output logic                          m_axis_tuser
);

    logic                 face_valid;
    taa_pkg::t_face       face;
    logic                 face_ready;
    logic                 q_full;
    logic                 q_valid;
    taa_pkg::t_face       q_data;
    logic                 pop;
    logic                 res_valid;
    taa_pkg::t_result     res;
    logic                 res_ready;
    taa_pkg::t_back_stat  stat;
    logic                 r_out_valid;
    taa_pkg::t_result     r_out;

    assign face_ready = !q_full;

    taa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_face_valid  (face_valid),
        .o_face        (face),
        .i_face_ready  (face_ready)
    );

    taa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (face_valid),
        .i_data  (face),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    taa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_face_valid (q_valid),
        .i_face       (q_data),
        .o_pop        (pop),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_ready),
        .o_stat       (stat)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    // Output register: hold the result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.area;
    assign m_axis_tuser  = r_out.bad;

`ifndef ASSERT_OFF
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> stat.idle)
        else $error("back end took a face while busy");

    a_emit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.emit |=> m_axis_tvalid)
        else $error("result handed over but output register empty");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_full && face_valid) |=> face_valid)
        else $error("staged face lost while queue full");
`endif

endmodule

// ===== test/tb_top.sv =====
// Testbench for the triangle area accumulator: random triangles, scoreboard of object sums
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NumRandom  = 400;
    localparam int  CycleLimit = 2_000_000;
    localparam int  DrainWait  = 300;

    typedef struct packed {
        logic [3:0]                                         last;
        logic [taa_pkg::CountW-1:0]                         cnt;
        logic [taa_pkg::NumCoords-1:0][taa_pkg::CoordW-1:0] c;
    } t_face_in;

    // Object sum predictor and store of expected object results
    class area_scoreboard;
        logic [taa_pkg::AccW-1:0] area_total;
        logic                     bad_seen;
        taa_pkg::t_result         sums_due[$];
        int                       mismatches;

        function new();
            area_total = '0;
            bad_seen   = 1'b0;
            mismatches = 0;
        endfunction

        // Exact area of one triangle, Q.16, truncated
        function logic [taa_pkg::AccW-1:0] tri_area(
            logic [taa_pkg::NumCoords-1:0][taa_pkg::CoordW-1:0] c);
            logic signed [255:0] v [9];
            logic signed [255:0] d [3];
            logic signed [255:0] e [3];
            logic signed [255:0] cr;
            logic        [255:0] sq_sum;
            logic        [255:0] root;
            logic        [255:0] cand;
            logic        [255:0] shifted;
            int j;
            int k;
            sq_sum = '0;
            for (int i = 0; i < 9; i++) v[i] = $signed(c[i]);
            for (int i = 0; i < 3; i++) begin
                d[i] = v[3+i] - v[i];
                e[i] = v[6+i] - v[i];
            end
            for (int i = 0; i < 3; i++) begin
                j = (i + 1) % 3;
                k = (i + 2) % 3;
                cr = d[j] * e[k] - d[k] * e[j];
                sq_sum = sq_sum + cr * cr;
            end
            root = '0;
            for (int b = 127; b >= 0; b--) begin
                cand = root | (256'd1 << b);
                if (cand * cand <= sq_sum) root = cand;
            end
            shifted = root >> taa_pkg::AreaShift;
            if (shifted[255:taa_pkg::AccW] != '0) return '1;
            return shifted[taa_pkg::AccW-1:0];
        endfunction

        // Note an accepted face transaction
        function void note_face(t_face_in f);
            logic [taa_pkg::AccW-1:0] a;
            taa_pkg::t_result r;
            if (f.cnt != taa_pkg::CountW'(taa_pkg::FaceVerts)) begin
                bad_seen = 1'b1;
            end else begin
                a = tri_area(f.c);
                if (a > ~area_total) area_total = '1;
                else area_total = area_total + a;
            end
            if (f.last[0]) begin
                r.area = area_total;
                r.bad  = bad_seen;
                sums_due = {sums_due, r};
                area_total = '0;
                bad_seen   = 1'b0;
            end
        endfunction

        // Compare an accepted result transaction with the oldest expectation
        function void check_sum(logic [taa_pkg::AccW-1:0] area, logic bad);
            taa_pkg::t_result r;
            if (sums_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: area %h bad %b", area, bad);
                return;
            end
            r = sums_due.pop_front();
            if (r.area !== area || r.bad !== bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: area exp %h got %h, bad exp %b got %b",
                             r.area, area, r.bad, bad);
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [taa_pkg::InDataW-1:0]     s_axis_tdata = '0;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [taa_pkg::AccW-1:0]        m_axis_tdata;
    logic                            m_axis_tuser;

    area_scoreboard sb = new();
    int  cycles = 0;
    bit  hold_req = 1'b0;
    int  burst_left = 0;

    triangle_area_accumulator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Check every result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_sum(m_axis_tdata, m_axis_tuser);
    end

    // Receiver: changing stall patterns and one long hold-off
    initial begin : receiver
        int mode;
        int phase;
        mode  = 0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (1500) @(posedge i_clk);
                hold_req = 1'b0;
            end
            phase++;
            if (phase % 300 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= (phase % 7) != 3;
                2: m_axis_tready <= $urandom_range(0, 3) != 0;
                default: m_axis_tready <= (phase % 40) < 10;
            endcase
        end
    end

    // Offer one face and hold it until accepted, then maybe leave a gap
    task automatic send_face(t_face_in f);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= taa_pkg::InDataW'(f)
                         & {{(taa_pkg::InDataW-taa_pkg::InRawW){1'b0}},
                            {taa_pkg::InRawW{1'b1}}};
        s_axis_tlast  <= f.last[0];
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_face(f);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic [taa_pkg::CoordW-1:0] rand_coord(int kind);
        case (kind)
            0: return taa_pkg::CoordW'($signed($urandom_range(0, 2000)) - 1000);
            1: return taa_pkg::CoordW'($signed($urandom_range(0, 32'h00FF_FFFF))
                                       - 32'sh0080_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_face_in make_face(logic [taa_pkg::CountW-1:0] cnt, bit last,
                                           logic [taa_pkg::CoordW-1:0] fill);
        t_face_in f;
        f.last = {3'b000, last};
        f.cnt  = cnt;
        for (int i = 0; i < taa_pkg::NumCoords; i++) f.c[i] = fill;
        return f;
    endfunction

    initial begin : stimulus
        t_face_in f;
        int kind;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: degenerate, extreme corners, every vertex count, last marks
        send_face(make_face(taa_pkg::CountW'(taa_pkg::FaceVerts), 1, 32'h0));
        f = make_face(taa_pkg::CountW'(taa_pkg::FaceVerts), 1, 32'h0);
        f.c[3] = 32'h7FFF_FFFF; f.c[7] = 32'h7FFF_FFFF;
        f.c[0] = 32'h8000_0000; f.c[4] = 32'h8000_0000; f.c[8] = 32'h8000_0000;
        send_face(f);
        f = make_face(taa_pkg::CountW'(taa_pkg::FaceVerts), 0, 32'h8000_0000);
        f.c[3] = 32'h7FFF_FFFF; f.c[5] = 32'h7FFF_FFFF;
        f.c[7] = 32'h7FFF_FFFF; f.c[8] = 32'h7FFF_FFFF;
        send_face(f);
        f = make_face(taa_pkg::CountW'(taa_pkg::FaceVerts), 1, 32'h7FFF_FFFF);
        f.c[4] = 32'h8000_0000; f.c[6] = 32'h8000_0000;
        send_face(f);
        // collinear points add nothing
        f = make_face(taa_pkg::CountW'(taa_pkg::FaceVerts), 1, 32'h0);
        f.c[3] = 32'h0001_0000; f.c[6] = 32'h0002_0000;
        send_face(f);
        // unit right triangle, area one half
        f = make_face(taa_pkg::CountW'(taa_pkg::FaceVerts), 1, 32'h0);
        f.c[3] = 32'h0001_0000; f.c[7] = 32'h0001_0000;
        send_face(f);
        for (int n = 0; n < 16; n++) begin
            f = make_face(taa_pkg::CountW'(n), n % 4 == 3, 32'h0);
            f.c[3] = 32'h0003_0000; f.c[7] = 32'h0002_0000;
            send_face(f);
        end
        f = make_face(4'd15, 1, 32'hFFFF_FFFF);
        send_face(f);

        // Random objects of mostly good faces; long receiver hold-off early on
        for (int n = 0; n < NumRandom; n++) begin
            if (n == 40) hold_req = 1'b1;
            kind = $urandom_range(0, 2);
            f.last = {3'b000, $urandom_range(0, 7) == 0};
            f.cnt  = ($urandom_range(0, 9) == 0) ? taa_pkg::CountW'($urandom)
                                                 : taa_pkg::CountW'(taa_pkg::FaceVerts);
            for (int i = 0; i < taa_pkg::NumCoords; i++) f.c[i] = rand_coord(kind);
            send_face(f);
        end
        f = make_face(taa_pkg::CountW'(taa_pkg::FaceVerts), 1, 32'h0);
        send_face(f);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        // Drain and settle
        while (sb.sums_due.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/taa_pkg.sv
hdl/taa_front.sv
hdl/taa_queue.sv
hdl/taa_back.sv
hdl/triangle_area_accumulator_core.sv
test/tb_top.sv
